// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of the demosaic block.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define BBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property checked at every edge, reset included.
`define BBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bbd_pkg.sv
// Types, register indexes and fixed constants of the Bayer demosaic block.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package bbd_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int PAT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [FH_W-1:0]  row_t;
  typedef logic [PAT_W-1:0] pattern_t;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CFA_PATTERN  = 2'd2;

  // color filter layouts
  localparam pattern_t CFA_BGGR = 2'd0;
  localparam pattern_t CFA_GBRG = 2'd1;
  localparam pattern_t CFA_GRBG = 2'd2;
  localparam pattern_t CFA_RGGB = 2'd3;

  localparam int       WIDTH_RST   = 640;
  localparam row_t     HEIGHT_RST  = 13'd480;
  localparam pattern_t PATTERN_RST = CFA_BGGR;

  localparam row_t MIN_HEIGHT = 13'd2;

  // per-pixel control decided at accept time, used in the compute stage
  typedef struct packed {
    logic left_new;    // left column mirrored from the incoming column
    logic right_left;  // right column mirrored from the left one
    logic top_mirror;  // top row taken from the bottom row
    logic bot_mirror;  // bottom row taken from the top row
    logic green_site;
    logic odd_row;
    logic swap_rb;
    logic eol;
    logic eof;
  } pix_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/bbd_ifs.sv
// Valid/ready stream interfaces: raw sample input and RGB pixel output.
// Depends on bbd_pkg for the payload types.
`default_nettype none

interface bbd_in_if;
  logic          valid;
  logic          ready;
  bbd_pkg::pix_t sample;
  logic          blank;

  modport source (output valid, output sample, output blank, input ready);
  modport sink   (input valid, input sample, input blank, output ready);
endinterface

interface bbd_out_if;
  logic          valid;
  logic          ready;
  bbd_pkg::pix_t blue;
  bbd_pkg::pix_t green;
  bbd_pkg::pix_t red;
  logic          end_of_line;
  logic          end_of_frame;

  modport source (output valid, output blue, output green, output red,
                  output end_of_line, output end_of_frame, input ready);
  modport sink   (input valid, input blue, input green, input red,
                  input end_of_line, input end_of_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bbd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bayer8_bilinear_demosaic.sv
// Bilinear Bayer demosaic, 8-bit raw samples in, one RGB pixel per sample out.
// Usage:
//   in_px  : raster-order raw samples; blank=1 marks a drain beat.
//   out_px : reconstructed pixels with end_of_line / end_of_frame flags.
//   cfg_*  : write-only registers (width, height, CFA layout); any write to
//            a listed register restarts the frame. Write only while idle.
// Throughput: one beat per cycle while out_px is not stalled, limited by the single read and
//   write port of each line store (one column per cycle).
// Latency: the beat that completes a neighborhood goes through the compute stage register and
//   then the result register; in stream terms output lags input by one line plus one pixel,
//   so each frame is followed by width+1 blank beats to drain the last row. Blank beats inside
//   a frame are taken and dropped.
// Reset: counters, window and config return to defaults at once; the line
//   stores are not cleared (no clearing pass); rows read from them before they are
//   written are not used, a mirrored row takes their place.
// Stall: a held result sits in the output register while one more beat can be
//   taken into the compute stage; in_px.ready drops only in reset or when both are full.
// Stores: two MAX_WIDTH x 8 RAMs, read at the accept cycle, written when the
//   beat of the frame leaves the compute stage.
`default_nettype none

module bayer8_bilinear_demosaic #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  bbd_in_if.sink                                  in_px,
  bbd_out_if.source                               out_px
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam logic [CW-1:0] W_RST =
    CW'((bbd_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bbd_pkg::WIDTH_RST);
  localparam logic [CW-1:0] MIN_W = CW'(2);

  // ---------------- configuration ----------------
  logic [CW-1:0]       eff_w;
  bbd_pkg::row_t       eff_h;
  bbd_pkg::pattern_t   pattern;
  logic [CW-1:0]       w_clamped;
  bbd_pkg::row_t       h_clamped;
  logic [bbd_pkg::FW_W-1:0] wv;
  logic                cfg_restart;

  assign wv = cfg_data[bbd_pkg::FW_W-1:0];

  always_comb begin
    if (wv < bbd_pkg::FW_W'(2)) begin
      w_clamped = MIN_W;
    end else if (int'(wv) > MAX_WIDTH) begin
      w_clamped = CW'(MAX_WIDTH);
    end else begin
      w_clamped = CW'(wv);
    end
    if (cfg_data[bbd_pkg::FH_W-1:0] < bbd_pkg::MIN_HEIGHT) begin
      h_clamped = bbd_pkg::MIN_HEIGHT;
    end else begin
      h_clamped = cfg_data[bbd_pkg::FH_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_index)
      bbd_pkg::REG_FRAME_WIDTH,
      bbd_pkg::REG_FRAME_HEIGHT,
      bbd_pkg::REG_CFA_PATTERN: cfg_restart = cfg_we;
      default:                  cfg_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w   <= W_RST;
      eff_h   <= bbd_pkg::HEIGHT_RST;
      pattern <= bbd_pkg::PATTERN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbd_pkg::REG_FRAME_WIDTH:  eff_w   <= w_clamped;
        bbd_pkg::REG_FRAME_HEIGHT: eff_h   <= h_clamped;
        bbd_pkg::REG_CFA_PATTERN:  pattern <= cfg_data[bbd_pkg::PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- accept stage ----------------
  logic [CW-1:0]     in_col, out_col;
  bbd_pkg::row_t     in_row, out_row;
  logic [CW-1:0]     w_m1, in_col_inc;
  bbd_pkg::row_t     h_m1;
  logic              in_acc, drain, live, emit, last_col, x_lsb, parity;
  logic              shift, wr;
  bbd_pkg::pix_ctl_t ctl;

  // stage 1 / output control
  logic              s1_valid, s1_emit, s1_shift, s1_wr, s1_adv;
  logic [AW-1:0]     s1_addr;
  bbd_pkg::pix_t     s1_bot;
  bbd_pkg::pix_ctl_t s1_ctl;
  logic              out_valid;

  assign in_acc     = in_px.valid && in_px.ready;
  assign w_m1       = eff_w - 1'b1;
  assign h_m1       = eff_h - 1'b1;
  assign in_col_inc = in_col + 1'b1;
  assign drain      = in_row >= eff_h;
  // after the frame every beat drains, whatever its blank bit
  assign live       = drain || !in_px.blank;
  assign emit       = (in_row >= bbd_pkg::FH_W'(2)) ||
                      (in_row == bbd_pkg::FH_W'(1) && in_col != '0);
  // last pixel of a line is made before the window shifts
  assign last_col   = out_col >= w_m1;
  assign shift      = in_col < eff_w;
  assign wr         = shift && !drain;
  assign x_lsb      = last_col ? w_m1[0] : out_col[0];
  assign parity     = x_lsb ^ out_row[0];

  always_comb begin
    ctl.left_new   = !last_col && out_col == '0;
    ctl.right_left = last_col;
    ctl.top_mirror = out_row == '0;
    ctl.bot_mirror = out_row == h_m1;
    ctl.green_site = (pattern == bbd_pkg::CFA_BGGR || pattern == bbd_pkg::CFA_RGGB) ?
                     parity : !parity;
    ctl.odd_row    = out_row[0];
    ctl.swap_rb    = pattern == bbd_pkg::CFA_GRBG || pattern == bbd_pkg::CFA_RGGB;
    ctl.eol        = last_col;
    ctl.eof        = last_col && out_row == h_m1;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (in_acc && live) begin
      if (emit && ctl.eof) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (!drain && in_col_inc >= eff_w) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col_inc;
        end
        if (emit) begin
          if (last_col) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // ---------------- line stores ----------------
  bbd_pkg::pix_t top, mid;

  bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (s1_adv && s1_wr),
    .waddr (s1_addr),
    .wdata (mid),
    .re    (in_acc && live),
    .raddr (in_col[AW-1:0]),
    .rdata (top)
  );

  bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (s1_adv && s1_wr),
    .waddr (s1_addr),
    .wdata (s1_bot),
    .re    (in_acc && live),
    .raddr (in_col[AW-1:0]),
    .rdata (mid)
  );

  // ---------------- compute stage ----------------
  assign s1_adv      = s1_valid && (!s1_emit || !out_valid || out_px.ready);
  assign in_px.ready = !rst && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && live) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && live) begin
      s1_emit  <= emit;
      s1_shift <= shift;
      s1_wr    <= wr;
      s1_addr  <= in_col[AW-1:0];
      s1_bot   <= drain ? '0 : in_px.sample;
      s1_ctl   <= ctl;
    end
  end

  // window columns 1 and 2; rows 0 (oldest line) .. 2 (newest)
  bbd_pkg::pix_t win1 [3];
  bbd_pkg::pix_t win2 [3];
  bbd_pkg::pix_t ncol [3];

  assign ncol[0] = top;
  assign ncol[1] = mid;
  assign ncol[2] = s1_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        win1[k] <= '0;
        win2[k] <= '0;
      end
    end else if (s1_adv && s1_shift) begin
      for (int k = 0; k < 3; k++) begin
        win1[k] <= win2[k];
        win2[k] <= ncol[k];
      end
    end
  end

  bbd_pkg::pix_t lc [3];
  bbd_pkg::pix_t rc [3];
  bbd_pkg::pix_t lt, ct, rt, lb, cb, rb;
  bbd_pkg::pix_t hn, vn, di, g2;
  bbd_pkg::pix_t r_pre, g_pix, b_pre, r_pix, b_pix;
  logic [bbd_pkg::PIX_W:0]   sum_h, sum_v, sum_g;
  logic [bbd_pkg::PIX_W+1:0] sum_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lc[k] = s1_ctl.left_new   ? ncol[k] : win1[k];
      rc[k] = s1_ctl.right_left ? win1[k] : ncol[k];
    end
    lt = s1_ctl.top_mirror ? lc[2] : lc[0];
    ct = s1_ctl.top_mirror ? win2[2] : win2[0];
    rt = s1_ctl.top_mirror ? rc[2] : rc[0];
    lb = s1_ctl.bot_mirror ? lc[0] : lc[2];
    cb = s1_ctl.bot_mirror ? win2[0] : win2[2];
    rb = s1_ctl.bot_mirror ? rc[0] : rc[2];

    sum_h = {1'b0, lc[1]} + {1'b0, rc[1]};
    sum_v = {1'b0, ct} + {1'b0, cb};
    sum_d = {2'b00, lt} + {2'b00, rt} + {2'b00, lb} + {2'b00, rb};
    hn    = sum_h[bbd_pkg::PIX_W:1];
    vn    = sum_v[bbd_pkg::PIX_W:1];
    di    = sum_d[bbd_pkg::PIX_W+1:2];
    sum_g = {1'b0, vn} + {1'b0, hn};
    g2    = sum_g[bbd_pkg::PIX_W:1];

    if (s1_ctl.green_site) begin
      g_pix = win2[1];
      r_pre = s1_ctl.odd_row ? hn : vn;
      b_pre = s1_ctl.odd_row ? vn : hn;
    end else if (s1_ctl.odd_row) begin
      r_pre = win2[1];
      g_pix = g2;
      b_pre = di;
    end else begin
      b_pre = win2[1];
      g_pix = g2;
      r_pre = di;
    end
    r_pix = s1_ctl.swap_rb ? b_pre : r_pre;
    b_pix = s1_ctl.swap_rb ? r_pre : b_pre;
  end

  // ---------------- output register ----------------
  bbd_pkg::pix_t out_blue, out_green, out_red;
  logic          out_eol, out_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_px.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_blue  <= b_pix;
      out_green <= g_pix;
      out_red   <= r_pix;
      out_eol   <= s1_ctl.eol;
      out_eof   <= s1_ctl.eof;
    end
  end

  assign out_px.valid        = out_valid;
  assign out_px.blue         = out_blue;
  assign out_px.green        = out_green;
  assign out_px.red          = out_red;
  assign out_px.end_of_line  = out_eol;
  assign out_px.end_of_frame = out_eof;

endmodule

`default_nettype wire

// File: rtl/core/bbd_checker.sv
// Port-level checker for the Bayer demosaic top level, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bbd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_eol,
  input wire logic out_eof
);

  `BBD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped in stall")
  `BBD_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result valid right after reset")
  `BBD_ASSERT(a_eof_eol, out_valid && out_eof |-> out_eol, "frame end not on a line end")
  // a fresh result needs an input beat taken into the compute stage before it
  `BBD_ASSERT(a_rise_src, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "no input beat")

endmodule

bind bayer8_bilinear_demosaic bbd_checker u_bbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_px.valid),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .out_eol   (out_px.end_of_line),
  .out_eof   (out_px.end_of_frame)
);

`default_nettype wire
